@@ sv/rqts_pkg.sv @@
package rqts_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int KEY_W     = 12;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [1:0] POL_SJF  = 2'd0;
    localparam logic [1:0] POL_SRT  = 2'd1;
    localparam logic [1:0] POL_RR   = 2'd2;
    localparam logic [1:0] POL_PRIO = 2'd3;

    typedef struct packed {
        logic       op;
        logic [7:0] task_id;
        logic [7:0] svc_units;
        logic [3:0] task_priority;
    } t_in;

    typedef struct packed {
        logic        rejected;
        logic        ran_valid;
        logic [7:0]  ran_task;
        logic        finished;
        logic [15:0] turnaround;
        logic [15:0] waiting;
        logic [4:0]  queued;
    } t_out;

    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  svc;
        logic [7:0]  rem;
        logic [3:0]  prio;
        logic [15:0] arr;
    } t_entry;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_REMOVE,
        CMD_ROTATE,
        CMD_DEC
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ROT,
        ST_APPLY
    } t_state;

    typedef struct packed {
        t_cmd       cmd;
        logic [1:0] policy;
        logic       scan;
    } t_cell_ctl;

    // Ordering key: a smaller key wins the scan.
    function automatic logic [KEY_W-1:0] key_of(input t_entry e, input logic [1:0] pol);
        logic [KEY_W-1:0] k;
        case (pol)
            POL_SJF: k = {4'd0, e.svc};
            POL_SRT: k = {4'd0, e.rem};
            default: k = {e.prio, e.svc};
        endcase
        return k;
    endfunction

endpackage

@@ sv/ready_queue_task_scheduler_core.sv @@
// Ready-queue task scheduler.
// A transaction is taken at a rising edge with i_start high and o_busy low; its
// fields arrive on i_in. Each transaction yields exactly one result on o_out,
// shown for one cycle with o_done high; the receiver cannot stall, so it must
// take the result in that cycle.
// An arrive and a tick on an empty queue are answered straight from idle. A
// round robin tick passes through a rotate state and then an apply state, a
// shortest job first tick with a task already held goes straight to the apply
// state, and any other tick first scans the chain of queue cells, which
// carries the running best one cell per cycle, then applies. o_busy is low
// in the cycle o_done is high, so the next transaction can be taken there.
// The policy register is written through i_cfg_we / i_cfg_wdata; the user
// must write it only while idle, as the block does not enforce this. Reset
// empties the queue, drops any held task, clears the tick counter and selects
// shortest job first. Queue entries have no reset; only filled entries are ever read.
module ready_queue_task_scheduler_core import rqts_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_in        i_in,
    output logic       o_busy,
    output logic       o_done,
    output t_out       o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

    // Control state.
    t_state        r_state, n_state;
    logic [1:0]    r_policy;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_held, n_held;
    logic          r_held_v, n_held_v;
    logic [15:0]   r_tick, n_tick;
    logic [IW-1:0] r_step, n_step;
    logic [IW-1:0] r_sel, n_sel;
    logic          r_from_scan, n_from_scan;
    logic          r_done, n_done;
    t_out          r_out, n_out;

    // Chain wiring.
    t_entry           w_entry [DEPTH];
    logic [KEY_W-1:0] w_bkey  [DEPTH];
    logic [IW-1:0]    w_bidx  [DEPTH];
    t_cell_ctl        w_ctl;
    logic [IW-1:0]    w_target;
    t_entry           w_load;

    logic          w_accept;
    logic          w_held_eff;
    logic [IW-1:0] w_sel;
    t_entry        w_cur;
    logic          w_fin;
    logic [15:0]   w_ta;

    assign w_accept = i_start && (r_state == ST_IDLE);
    // A hold survives only under shortest job first and only if its slot is still filled.
    assign w_held_eff = r_held_v && (r_policy == POL_SJF) && (CW'(r_held) < r_count);
    assign w_sel = r_from_scan ? w_bidx[DEPTH-1] : r_sel;
    assign w_cur = w_entry[w_sel];
    assign w_fin = (w_cur.rem <= 8'd1);
    assign w_ta  = r_tick + 16'd1 - w_cur.arr;

    assign w_load.id   = i_in.task_id;
    assign w_load.svc  = i_in.svc_units;
    assign w_load.rem  = i_in.svc_units;
    assign w_load.prio = i_in.task_priority;
    assign w_load.arr  = r_tick;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            rqts_cell #(
                .DEPTH (DEPTH),
                .IDX   (g)
            ) u_cell (
                .i_clk    (i_clk),
                .i_ctl    (w_ctl),
                .i_target (w_target),
                .i_count  (r_count),
                .i_step   (r_step),
                .i_load   (w_load),
                .i_next   (w_entry[(g < DEPTH - 1) ? g + 1 : g]),
                .i_head   (w_entry[0]),
                .i_bkey   (w_bkey[(g > 0) ? g - 1 : 0]),
                .i_bidx   (w_bidx[(g > 0) ? g - 1 : 0]),
                .o_entry  (w_entry[g]),
                .o_bkey   (w_bkey[g]),
                .o_bidx   (w_bidx[g])
            );
        end
    endgenerate

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_in.op == OP_TICK && r_count != '0) begin
                    if (r_policy == POL_RR) begin
                        n_state = ST_ROT;
                    end else if (w_held_eff) begin
                        n_state = ST_APPLY;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_step == LAST) begin
                    n_state = ST_APPLY;
                end
            end
            ST_ROT:   n_state = ST_APPLY;
            ST_APPLY: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Datapath and cell commands.
    always_comb begin
        n_count     = r_count;
        n_held      = r_held;
        n_held_v    = r_held_v;
        n_tick      = r_tick;
        n_step      = r_step;
        n_sel       = r_sel;
        n_from_scan = r_from_scan;
        n_done      = 1'b0;
        n_out       = r_out;
        w_ctl.cmd    = CMD_NONE;
        w_ctl.policy = r_policy;
        w_ctl.scan   = 1'b0;
        w_target     = r_sel;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out = '0;
                    if (i_in.op == OP_ARRIVE) begin
                        n_done = 1'b1;
                        if (r_count >= CW'(DEPTH)) begin
                            n_out.rejected = 1'b1;
                        end else begin
                            w_ctl.cmd = CMD_LOAD;
                            n_count   = r_count + CW'(1);
                        end
                        n_out.queued = 5'(n_count);
                    end else begin
                        n_held_v = w_held_eff;
                        n_step   = '0;
                        if (r_count == '0) begin
                            n_done       = 1'b1;
                            n_tick       = r_tick + 16'd1;
                            n_out.queued = 5'(r_count);
                        end else if (r_policy == POL_RR) begin
                            n_from_scan = 1'b0;
                            n_sel       = IW'(r_count - CW'(1));
                        end else if (w_held_eff) begin
                            n_from_scan = 1'b0;
                            n_sel       = r_held;
                        end else begin
                            n_from_scan = 1'b1;
                        end
                    end
                end
            end
            ST_SCAN: begin
                w_ctl.scan = 1'b1;
                n_step     = r_step + IW'(1);
            end
            ST_ROT: begin
                w_ctl.cmd = CMD_ROTATE;
            end
            ST_APPLY: begin
                w_target = w_sel;
                n_done   = 1'b1;
                n_tick   = r_tick + 16'd1;
                if (r_from_scan && r_policy == POL_SJF) begin
                    n_held   = w_sel;
                    n_held_v = 1'b1;
                end
                n_out           = '0;
                n_out.ran_valid = 1'b1;
                n_out.ran_task  = w_cur.id;
                if (w_fin) begin
                    w_ctl.cmd        = CMD_REMOVE;
                    n_count          = r_count - CW'(1);
                    n_out.finished   = 1'b1;
                    n_out.turnaround = w_ta;
                    n_out.waiting    = (w_ta > {8'd0, w_cur.svc}) ? w_ta - {8'd0, w_cur.svc}
                                                                  : 16'd0;
                    // The held slot follows the gap closing behind the removed task.
                    if (n_held_v) begin
                        if (n_held == w_sel) begin
                            n_held_v = 1'b0;
                        end else if (n_held > w_sel) begin
                            n_held = n_held - IW'(1);
                        end
                    end
                end else begin
                    w_ctl.cmd = CMD_DEC;
                end
                n_out.queued = 5'(n_count);
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_policy <= POL_SJF;
            r_count  <= '0;
            r_held   <= '0;
            r_held_v <= 1'b0;
            r_tick   <= '0;
            r_step   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_held   <= n_held;
            r_held_v <= n_held_v;
            r_tick   <= n_tick;
            r_step   <= n_step;
            r_done   <= n_done;
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel       <= n_sel;
        r_from_scan <= n_from_scan;
        r_out       <= n_out;
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_out  = r_out;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result shown while a transaction is still in work");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    a_tick_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_in.op == OP_TICK && r_count != '0) |=> o_busy)
        else $error("tick on a filled queue did not start work");

    a_finish_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.finished) |-> (o_out.ran_valid && !o_out.rejected))
        else $error("finished flag without a task that ran");
`endif

endmodule

@@ sv/rqts_cell.sv @@
module rqts_cell import rqts_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX   = 0,
    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [IW-1:0]    i_target,
    input  logic [CW-1:0]    i_count,
    input  logic [IW-1:0]    i_step,
    input  t_entry           i_load,
    input  t_entry           i_next,
    input  t_entry           i_head,
    input  logic [KEY_W-1:0] i_bkey,
    input  logic [IW-1:0]    i_bidx,
    output t_entry           o_entry,
    output logic [KEY_W-1:0] o_bkey,
    output logic [IW-1:0]    o_bidx
);

    localparam logic [IW-1:0] MY   = IW'(IDX);
    localparam logic [CW-1:0] MY_C = CW'(IDX);

    t_entry           r_entry, n_entry;
    logic [KEY_W-1:0] r_bkey, n_bkey, w_key;
    logic [IW-1:0]    r_bidx, n_bidx;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.cmd)
            CMD_LOAD: begin
                if (MY_C == i_count) begin
                    n_entry = i_load;
                end
            end
            CMD_REMOVE: begin
                if (MY >= i_target) begin
                    n_entry = i_next;
                end
            end
            CMD_ROTATE: begin
                if (MY_C + CW'(1) == i_count) begin
                    n_entry = i_head;
                end else if (MY_C + CW'(1) < i_count) begin
                    n_entry = i_next;
                end
            end
            CMD_DEC: begin
                if (MY == i_target) begin
                    n_entry.rem = r_entry.rem - 8'd1;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    // The running best hops one cell per scan step; this cell joins when the step reaches it.
    always_comb begin
        w_key  = key_of(r_entry, i_ctl.policy);
        n_bkey = r_bkey;
        n_bidx = r_bidx;
        if (i_ctl.scan && i_step == MY) begin
            if (MY_C < i_count && (IDX == 0 || w_key < i_bkey)) begin
                n_bkey = w_key;
                n_bidx = MY;
            end else begin
                n_bkey = i_bkey;
                n_bidx = i_bidx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_bkey  <= n_bkey;
        r_bidx  <= n_bidx;
    end

    assign o_entry = r_entry;
    assign o_bkey  = r_bkey;
    assign o_bidx  = r_bidx;

endmodule

@@ bench/ready_queue_task_scheduler_checker.sv @@
`timescale 1ns / 100ps

// Watches the transaction and result channels of the scheduler, keeps its own
// copy of the ready queue and compares every result with the predicted one.
module ready_queue_task_scheduler_checker import rqts_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_in         i_in,
    input  logic        i_busy,
    input  logic        i_done,
    input  t_out        i_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_fill,
    output logic [15:0] o_ticks
);

    t_entry      slots [DEPTH];
    int          slot_count;
    int          held_idx;
    logic        held_ok;
    logic [15:0] tick_now;
    logic [1:0]  cur_policy;
    t_out        expected_results [$];

    assign o_pending = expected_results.size();
    assign o_fill    = slot_count;
    assign o_ticks   = tick_now;

    // True when slot a wins over slot b under the current policy.
    function automatic logic wins(input t_entry a, input t_entry b, input logic [1:0] pol);
        if (pol == POL_SJF) return a.svc < b.svc;
        if (pol == POL_SRT) return a.rem < b.rem;
        if (a.prio != b.prio) return a.prio < b.prio;
        return a.svc < b.svc;
    endfunction

    task automatic schedule_item(input t_in it, output t_out r);
        int     sel;
        t_entry front;
        r = '0;
        if (it.op == OP_ARRIVE) begin
            if (slot_count >= DEPTH) begin
                r.rejected = 1'b1;
            end else begin
                slots[slot_count] = '{id: it.task_id, svc: it.svc_units,
                                      rem: it.svc_units, prio: it.task_priority,
                                      arr: tick_now};
                slot_count++;
            end
        end else begin
            if (cur_policy != POL_SJF) held_ok = 1'b0;
            if (held_ok && held_idx >= slot_count) held_ok = 1'b0;
            if (slot_count > 0) begin
                if (cur_policy == POL_RR) begin
                    // The front task moves to the back and runs there.
                    front = slots[0];
                    for (int i = 0; i + 1 < slot_count; i++) slots[i] = slots[i + 1];
                    slots[slot_count - 1] = front;
                    sel = slot_count - 1;
                end else if (cur_policy == POL_SJF && held_ok) begin
                    sel = held_idx;
                end else begin
                    sel = 0;
                    for (int i = 1; i < slot_count; i++)
                        if (wins(slots[i], slots[sel], cur_policy)) sel = i;
                    if (cur_policy == POL_SJF) begin
                        held_idx = sel;
                        held_ok  = 1'b1;
                    end
                end
                r.ran_valid = 1'b1;
                r.ran_task  = slots[sel].id;
                if (slots[sel].rem <= 8'd1) begin
                    r.finished   = 1'b1;
                    r.turnaround = tick_now + 16'd1 - slots[sel].arr;
                    r.waiting    = (r.turnaround > {8'd0, slots[sel].svc}) ?
                                   r.turnaround - {8'd0, slots[sel].svc} : 16'd0;
                    for (int i = sel; i + 1 < slot_count; i++) slots[i] = slots[i + 1];
                    slot_count--;
                    if (held_ok) begin
                        if (held_idx == sel) held_ok = 1'b0;
                        else if (held_idx > sel) held_idx--;
                    end
                end else begin
                    slots[sel].rem--;
                end
            end
            tick_now++;
        end
        r.queued = slot_count[4:0];
    endtask

    always @(posedge i_clk) begin
        t_out want;
        t_out pred;
        logic bad;
        if (!i_rst_n) begin
            slot_count = 0;
            held_idx   = 0;
            held_ok    = 1'b0;
            tick_now   = '0;
            cur_policy = POL_SJF;
            o_errors   = 0;
            expected_results.delete();
        end else begin
            // A result is compared before the transaction taken at this edge is added.
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("Unexpected result %p", i_out);
                end else begin
                    want = expected_results.pop_front();
                    bad  = (want.rejected   !== i_out.rejected)   ||
                           (want.ran_valid  !== i_out.ran_valid)  ||
                           (want.ran_task   !== i_out.ran_task)   ||
                           (want.finished   !== i_out.finished)   ||
                           (want.turnaround !== i_out.turnaround) ||
                           (want.waiting    !== i_out.waiting)    ||
                           (want.queued     !== i_out.queued);
                    if (bad) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("Mismatch: expected %p, got %p", want, i_out);
                    end
                end
            end
            if (i_start && !i_busy) begin
                schedule_item(i_in, pred);
                expected_results.push_back(pred);
            end
            if (i_cfg_we) cur_policy = i_cfg_wdata;
        end
    end

endmodule

@@ bench/tb_ready_queue_task_scheduler_core.sv @@
`timescale 1ns / 100ps

// Stimulus and verdict for the ready-queue scheduler. The checker beside the
// block does all the prediction and comparison; this module only feeds
// transactions, changes the policy between phases and reports the outcome.
module tb_ready_queue_task_scheduler_core;
    import rqts_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 3_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    t_in         i_in = '0;
    logic        o_busy;
    logic        o_done;
    t_out        o_out;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_wdata = '0;

    int          errors;
    int          pending;
    int          fill_now;
    logic [15:0] ticks;

    // The busy flag is sampled at the falling edge so that the driver knows,
    // at the next rising edge, whether its transaction was taken there.
    logic        busy_seen;
    int          burst_left = 0;
    int          cycles = 0;
    int          items_sent = 0;
    int          phases_run = 0;

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) busy_seen = o_busy;

    // Watchdog: any hang of the handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    ready_queue_task_scheduler_core #(.DEPTH(DEPTH)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_in        (i_in),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    ready_queue_task_scheduler_checker #(.DEPTH(DEPTH)) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_in        (i_in),
        .i_busy      (o_busy),
        .i_done      (o_done),
        .i_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_fill      (fill_now),
        .o_ticks     (ticks)
    );

    // Offers one transaction and returns at the edge that accepts it. Between
    // bursts the start line drops for a random number of cycles.
    task automatic send_item(input t_in it);
        if (burst_left == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        i_start <= 1'b1;
        i_in    <= it;
        do @(posedge i_clk); while (busy_seen);
        burst_left--;
        items_sent++;
    endtask

    task automatic arrive(input logic [7:0] id, input logic [7:0] svc, input logic [3:0] pr);
        send_item('{op: OP_ARRIVE, task_id: id, svc_units: svc, task_priority: pr});
    endtask

    task automatic tick();
        t_in         it;
        logic [31:0] noise;
        // Unused fields carry noise on ticks; the block must ignore them.
        noise = $urandom;
        it    = noise[$bits(t_in)-1:0];
        it.op = OP_TICK;
        send_item(it);
    endtask

    // Waits until every expected result has arrived, then lets the longest
    // scan latency pass so that the block is certainly idle.
    task automatic wait_quiet();
        i_start <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic set_policy(input logic [1:0] pol);
        wait_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= pol;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic drain_queue();
        wait_quiet();
        while (fill_now > 0) begin
            tick();
            wait_quiet();
        end
    endtask

    // One random phase. Most service times are short so tasks keep finishing;
    // the arrive share varies so the queue both runs dry and fills up.
    task automatic random_phase(input int count);
        int   arrive_pct;
        logic [7:0] svc;
        arrive_pct = $urandom_range(30, 70);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < arrive_pct) begin
                case ($urandom_range(0, 9))
                    0:       svc = 8'($urandom);
                    1:       svc = 8'd0;
                    default: svc = 8'($urandom_range(1, 6));
                endcase
                arrive(8'($urandom), svc, 4'($urandom));
            end else begin
                tick();
            end
        end
        phases_run++;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under shortest job first: the extremes of each field,
        // a zero service time, an idle tick and an arrival into a full queue.
        tick();
        arrive(8'd0, 8'd255, 4'd15);
        arrive(8'd255, 8'd0, 4'd0);
        arrive(8'h5a, 8'd1, 4'd1);
        arrive(8'ha5, 8'd2, 4'd7);
        repeat (4) tick();
        for (int k = 0; k < DEPTH; k++) arrive(k[7:0] + 8'd16, 8'd3, k[3:0]);
        arrive(8'd99, 8'd1, 4'd1);
        repeat (3) tick();

        // Switching policy releases any hold, though here the held task finishes before the first switch.
        set_policy(POL_PRIO);
        repeat (3) tick();
        set_policy(POL_RR);
        repeat (3) tick();
        set_policy(POL_SRT);
        drain_queue();

        // Random phases across all settings, the extremes among them.
        random_phase(100);
        set_policy(POL_RR);
        random_phase(100);
        set_policy(POL_PRIO);
        random_phase(100);
        set_policy(POL_SJF);
        random_phase(100);
        set_policy(POL_SRT);
        random_phase(50);
        set_policy(POL_PRIO);
        random_phase(50);

        wait_quiet();
        $display("Covered %0d transactions in %0d random phases over all four policies,",
                 items_sent, phases_run);
        $display("with full-queue rejects and idle ticks; the tick counter ended at %0d.",
                 ticks);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule
